// ===== sv/tmp_pkg.sv =====
package tmp_pkg;

   localparam int TimeW  = 32;
   localparam int DistW  = 40;
   localparam int AccW   = 33;
   localparam int CsrIdxW = 2;
   localparam int CsrDataW = 40;
   localparam int QueueDepth = 4;
   localparam int QueuePtrW = 2;

   typedef enum logic [1:0] {
      PH_ACCEL  = 2'd0,
      PH_CRUISE = 2'd1,
      PH_DECEL  = 2'd2,
      PH_DONE   = 2'd3
   } phase_type;

   localparam logic [CsrIdxW-1:0] REG_MAX_ACCEL    = 2'd0;
   localparam logic [CsrIdxW-1:0] REG_CRUISE_SPEED = 2'd1;
   localparam logic [CsrIdxW-1:0] REG_TRAVEL       = 2'd2;

   // derived profile timing, held stable between configuration writes
   typedef struct packed {
      logic [31:0] accel;
      logic [31:0] speed;
      logic [31:0] ramp_time;
      logic [31:0] cruise_time;
      logic [32:0] total_time;
      logic [39:0] end_distance;
      logic [39:0] base_pos;
   } prof_type;

   // classified request handed from front to back
   typedef struct packed {
      phase_type   phase;
      logic [31:0] dt;
   } job_type;

   typedef struct packed {
      logic [39:0] position;
      logic [31:0] velocity;
      logic [32:0] acceleration;
      phase_type   phase;
   } rsp_type;

endpackage

// ===== sv/tmp_divider.sv =====
// restoring divider, one quotient bit per cycle, 64-bit numerator
module tmp_divider (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [63:0] quot
);
   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [32:0] trial;

   always_comb begin
      q_in    = q_ff;
      r_in    = r_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {r_ff[31:0], q_ff[63]};
      if (start) begin
         q_in    = num;
         r_in    = '0;
         cnt_in  = 7'd64;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den}) begin
            r_in = trial - {1'b0, den};
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   // zero divisor gives all ones naturally with restoring division
   assign done = done_ff;
   assign quot = q_ff;
endmodule

// ===== sv/tmp_setup.sv =====
// recomputes the profile timing after each configuration write
module tmp_setup (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [tmp_pkg::CsrIdxW-1:0]      csr_index,
   input  logic [tmp_pkg::CsrDataW-1:0]     csr_data,
   output tmp_pkg::prof_type                prof
);
   import tmp_pkg::*;

   typedef enum logic [8:0] {
      S_IDLE  = 9'b000000001,
      S_SQR   = 9'b000000010,
      S_DIV1  = 9'b000000100,
      S_WAIT1 = 9'b000001000,
      S_DIV2  = 9'b000010000,
      S_WAIT2 = 9'b000100000,
      S_DIV3  = 9'b001000000,
      S_WAIT3 = 9'b010000000,
      S_BASE  = 9'b100000000
   } st_type;

   st_type      st_ff, st_in;
   logic [31:0] accel_ff, accel_in, speed_ff, speed_in;
   logic [39:0] travel_ff, travel_in;
   prof_type    prof_ff, prof_in;
   logic [39:0] minT_ff, minT_in;
   logic [63:0] sq_ff, sq_in;
   logic [63:0] bprod_ff, bprod_in;
   logic        dstart;
   logic [63:0] dnum, dquot;
   logic [31:0] dden;
   logic        ddone;
   logic [39:0] endd, rest;
   logic [33:0] tsum;
   logic [63:0] bhi, blo;
   logic [63:0] bhi_ff, blo_ff;
   logic [63:0] rb;

   tmp_divider u_div (
      .clock(clock), .reset(reset), .start(dstart), .num(dnum), .den(dden),
      .done(ddone), .quot(dquot)
   );

   assign csr_ready = (st_ff == S_IDLE);

   // base position at end of ramp: a*Tr*Tr/2^33, split in two 32-bit halves
   always_comb begin
      bhi = {32'd0, bprod_ff[63:32]} * {32'd0, prof_ff.ramp_time};
      blo = {32'd0, bprod_ff[31:0]} * {32'd0, prof_ff.ramp_time};
      rb  = {1'b0, bhi_ff[63:1]}
          + {32'd0, 32'(({1'b0, bhi_ff[0], 31'd0} + {1'b0, blo_ff[63:1]}) >> 32)};
   end

   always_comb begin
      st_in     = st_ff;
      accel_in  = accel_ff;
      speed_in  = speed_ff;
      travel_in = travel_ff;
      prof_in   = prof_ff;
      minT_in   = minT_ff;
      sq_in     = sq_ff;
      bprod_in  = bprod_ff;
      dstart    = 1'b0;
      dnum      = '0;
      dden      = accel_ff;
      endd      = (travel_ff < minT_ff) ? minT_ff : travel_ff;
      rest      = endd - minT_ff;
      tsum      = {1'b0, prof_ff.ramp_time, 1'b0} + {2'b0, prof_ff.cruise_time};
      case (st_ff)
         S_IDLE: begin
            if (csr_valid) begin
               case (csr_index)
                  REG_MAX_ACCEL:    begin accel_in = csr_data[31:0]; st_in = S_SQR; end
                  REG_CRUISE_SPEED: begin speed_in = csr_data[31:0]; st_in = S_SQR; end
                  REG_TRAVEL:       begin travel_in = csr_data; st_in = S_SQR; end
                  default:          st_in = S_IDLE;
               endcase
            end
         end
         S_SQR: begin
            sq_in = {32'd0, speed_ff} * {32'd0, speed_ff};
            st_in = S_DIV1;
         end
         S_DIV1: begin
            dstart = 1'b1;
            dnum   = {16'd0, speed_ff, 16'd0};
            st_in  = S_WAIT1;
         end
         S_WAIT1: begin
            if (ddone) begin
               prof_in.ramp_time = (dquot[63:32] != '0) ? '1 : dquot[31:0];
               st_in = S_DIV2;
            end
         end
         S_DIV2: begin
            dstart   = 1'b1;
            dnum     = sq_ff;
            // ramp time is settled here; the halves are ready long before S_BASE
            bprod_in = {32'd0, accel_ff} * {32'd0, prof_ff.ramp_time};
            st_in    = S_WAIT2;
         end
         S_WAIT2: begin
            if (ddone) begin
               minT_in = (dquot[63:40] != '0) ? '1 : dquot[39:0];
               st_in = S_DIV3;
            end
         end
         S_DIV3: begin
            dstart = 1'b1;
            dnum   = {8'd0, rest, 16'd0};
            dden   = speed_ff;
            prof_in.end_distance = endd;
            st_in  = S_WAIT3;
         end
         S_WAIT3: begin
            dden = speed_ff;
            if (ddone) begin
               prof_in.cruise_time = (dquot[63:32] != '0) ? '1 : dquot[31:0];
               st_in = S_BASE;
            end
         end
         S_BASE: begin
            prof_in.total_time = tsum[33] ? '1 : tsum[32:0];
            prof_in.accel = accel_ff;
            prof_in.speed = speed_ff;
            prof_in.base_pos = (rb[63:40] != '0) ? '1 : rb[39:0];
            st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff     <= S_IDLE;
         accel_ff  <= 32'd65536;
         speed_ff  <= 32'd65536;
         travel_ff <= '0;
         prof_ff   <= '{accel: 32'd65536, speed: 32'd65536, default: '0};
         minT_ff   <= '0;
      end else begin
         st_ff     <= st_in;
         accel_ff  <= accel_in;
         speed_ff  <= speed_in;
         travel_ff <= travel_in;
         prof_ff   <= prof_in;
         minT_ff   <= minT_in;
      end
      sq_ff    <= sq_in;
      bprod_ff <= bprod_in;
      bhi_ff   <= bhi;
      blo_ff   <= blo;
   end

   assign prof = prof_ff;
endmodule

// ===== sv/tmp_front.sv =====
// classifies a query time into its phase and the time offset used by the back
module tmp_front (
   input  logic                clock,
   input  logic                reset,
   input  tmp_pkg::prof_type   prof,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [31:0]         in_time,
   output logic                q_valid,
   input  logic                q_ready,
   output tmp_pkg::job_type    q_job
);
   import tmp_pkg::*;

   job_type     mem [QueueDepth];
   logic [QueuePtrW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QueuePtrW:0]   cnt_ff, cnt_in;
   job_type     job;
   logic [32:0] t33, tr33, trc;
   logic [32:0] dd;
   logic        push, pop;

   always_comb begin
      t33  = {1'b0, in_time};
      tr33 = {1'b0, prof.ramp_time};
      trc  = tr33 + {1'b0, prof.cruise_time};
      dd   = prof.total_time - t33;
      job.dt = '0;
      if (t33 < tr33) begin
         job.phase = PH_ACCEL;
         job.dt    = in_time;
      end else if (t33 < trc) begin
         job.phase = PH_CRUISE;
         job.dt    = in_time - prof.ramp_time;
      end else if (t33 <= prof.total_time) begin
         job.phase = PH_DECEL;
         job.dt    = dd[32] ? '1 : dd[31:0];
      end else begin
         job.phase = PH_DONE;
      end
   end

   assign in_ready = (cnt_ff != QueueDepth[QueuePtrW:0]);
   assign push     = in_valid && in_ready;
   assign q_valid  = (cnt_ff != '0);
   assign pop      = q_valid && q_ready;
   assign q_job    = mem[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + {{QueuePtrW{1'b0}}, push} - {{QueuePtrW{1'b0}}, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push)
         mem[wr_ff] <= job;
   end
endmodule

// ===== sv/tmp_back.sv =====
// three-stage evaluation: a*dt, then (a*dt)*dt halves, then combine
module tmp_back (
   input  logic              clock,
   input  logic              reset,
   input  tmp_pkg::prof_type prof,
   input  logic              q_valid,
   output logic              q_ready,
   input  tmp_pkg::job_type  q_job,
   output logic              out_valid,
   input  logic              out_ready,
   output tmp_pkg::rsp_type  out_rsp
);
   import tmp_pkg::*;

   logic    v1_ff, v2_ff, v3_ff;
   job_type j1_ff, j2_ff;
   logic [63:0] p_ff;
   logic [63:0] hi_ff, lo_ff;
   logic [63:0] vp_ff;
   rsp_type r3_ff, r3_in;
   logic    adv;
   logic [63:0] hi, lo, rb, run;
   logic [39:0] back;
   logic [40:0] psum;

   // stall the whole pipe when the output register is held
   assign adv     = !v3_ff || out_ready;
   assign q_ready = adv;

   always_comb begin
      hi = {32'd0, p_ff[63:32]} * {32'd0, j1_ff.dt};
      lo = {32'd0, p_ff[31:0]} * {32'd0, j1_ff.dt};
   end

   always_comb begin
      rb   = {1'b0, hi_ff[63:1]}
           + {32'd0, 32'(({1'b0, hi_ff[0], 31'd0} + {1'b0, lo_ff[63:1]}) >> 32)};
      back = (rb[63:40] != '0) ? '1 : rb[39:0];
      run  = {32'd0, prof.speed} * {32'd0, j2_ff.dt};
      psum = {1'b0, prof.base_pos} + {17'd0, run[63:40]};
      r3_in.phase = j2_ff.phase;
      case (j2_ff.phase)
         PH_ACCEL: begin
            r3_in.position     = back;
            r3_in.velocity     = (vp_ff[63:48] != '0) ? '1 : vp_ff[47:16];
            r3_in.acceleration = {1'b0, prof.accel};
         end
         PH_CRUISE: begin
            psum = {1'b0, prof.base_pos} + {1'b0, run[55:16]};
            r3_in.position     = (psum[40] || run[63:56] != '0) ? '1 : psum[39:0];
            r3_in.velocity     = prof.speed;
            r3_in.acceleration = '0;
         end
         PH_DECEL: begin
            r3_in.position     = (back > prof.end_distance) ? '0
                                 : prof.end_distance - back;
            r3_in.velocity     = (vp_ff[63:48] != '0) ? '1 : vp_ff[47:16];
            r3_in.acceleration = 33'd0 - {1'b0, prof.accel};
         end
         default: begin
            r3_in.position     = prof.end_distance;
            r3_in.velocity     = '0;
            r3_in.acceleration = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= q_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (adv) begin
         j1_ff <= q_job;
         p_ff  <= {32'd0, prof.accel} * {32'd0, q_job.dt};
         j2_ff <= j1_ff;
         hi_ff <= hi;
         lo_ff <= lo;
         vp_ff <= p_ff;
         r3_ff <= r3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_rsp   = r3_ff;
endmodule

// ===== sv/trapezoidal_motion_profile.sv =====
// Trapezoidal move profile: each request carries a query time (Q16.16 s) and
// returns position (Q24.16), speed, signed acceleration and phase. Requests
// are taken one per cycle while the queue has room; results pass through a
// front classifier, a four-entry queue and a three-stage multiply pipeline.
// A configuration write recomputes ramp, cruise and total time with a
// bit-serial divider; the block takes no further write until that ends.
module trapezoidal_motion_profile (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [31:0]  req_tdata,   // query_time
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [111:0] rsp_tdata,   // position, velocity, acceleration, phase, pad
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [39:0]  csr_data
);
   import tmp_pkg::*;

   prof_type prof;
   logic     q_valid, q_ready;
   job_type  q_job;
   rsp_type  rsp;

   tmp_setup u_setup (
      .clock(clock), .reset(reset), .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data), .prof(prof)
   );

   tmp_front u_front (
      .clock(clock), .reset(reset), .prof(prof), .in_valid(req_tvalid),
      .in_ready(req_tready), .in_time(req_tdata), .q_valid(q_valid),
      .q_ready(q_ready), .q_job(q_job)
   );

   tmp_back u_back (
      .clock(clock), .reset(reset), .prof(prof), .q_valid(q_valid),
      .q_ready(q_ready), .q_job(q_job), .out_valid(rsp_tvalid),
      .out_ready(rsp_tready), .out_rsp(rsp)
   );

   assign rsp_tdata = {5'd0, rsp.phase, rsp.acceleration, rsp.velocity, rsp.position};

   a_fin_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.phase == PH_DONE |-> rsp.velocity == '0 && rsp.acceleration == '0)
      else $error("finished result with motion");
   a_cruise_acc: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp.phase == PH_CRUISE |-> rsp.acceleration == '0)
      else $error("cruise with acceleration");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped while stalled");
endmodule
